// ----- rtl/irpw_pkg.sv -----
// irpw_pkg: shared types and constants for the infrared frame transmitter.
// No dependencies; imported by the top level, its port checker and the bench.
`timescale 1ns / 1ps

package irpw_pkg;

  // Widths of the fixed register and payload fields
  localparam int unsigned LEN_W      = 10;
  localparam int unsigned IDX_W      = 5;
  localparam int unsigned CMD_W      = 32;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned BITPOS_W   = 6;
  localparam int unsigned PHASE_W    = 3;

  typedef logic [LEN_W-1:0]      len_t;
  typedef logic [IDX_W-1:0]      bit_idx_t;
  typedef logic [CMD_W-1:0]      cmd_t;
  typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;
  typedef logic [BITPOS_W-1:0]   bitpos_t;
  typedef logic [PHASE_W-1:0]    phase_t;

  // Configuration register indexes
  localparam cfg_addr_t REG_HEADER_TICKS   = 3'd0;
  localparam cfg_addr_t REG_GAP_TICKS      = 3'd1;
  localparam cfg_addr_t REG_ZERO_TICKS     = 3'd2;
  localparam cfg_addr_t REG_ONE_TICKS      = 3'd3;
  localparam cfg_addr_t REG_LAST_BIT_INDEX = 3'd4;

  // Register reset values
  localparam len_t     RST_HEADER_TICKS   = 10'd24;
  localparam len_t     RST_GAP_TICKS      = 10'd6;
  localparam len_t     RST_ZERO_TICKS     = 10'd6;
  localparam len_t     RST_ONE_TICKS      = 10'd12;
  localparam bit_idx_t RST_LAST_BIT_INDEX = 5'd23;

  // Frame phase codes
  localparam phase_t PH_IDLE = 3'd0;
  localparam phase_t PH_HEAD = 3'd1;
  localparam phase_t PH_HGAP = 3'd2;
  localparam phase_t PH_MARK = 3'd3;
  localparam phase_t PH_BGAP = 3'd4;

  // Input beat kinds (in_tuser)
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SEND = 1'b1;

  // Result tdata bit positions
  localparam int unsigned OUT_CARRIER_BIT = 0;
  localparam int unsigned OUT_BUSY_BIT    = 1;

endpackage

// ----- rtl/ir_pulse_width_frame_transmitter.sv -----
// ir_pulse_width_frame_transmitter: single-channel IR pulse-width frame sender.
// Depends on irpw_pkg for register indexes, reset values and phase codes.
//
// Usage
//   Input stream (in_*): one beat per time tick or per send request.
//     in_tuser = 0 advances time by one tick; in_tuser = 1 loads in_tdata as
//     the command word and starts (or restarts) a frame.
//   Result stream (out_*): exactly one beat per input beat, in order.
//     out_tdata[0] carrier level for the tick, out_tdata[1] frame in progress,
//     out_tlast marks the tick on which the final bit mark ends.
//   Config port (cfg_*): register index and data, always ready; write it only
//     while the block is idle. Indexes beyond the register list are ignored.
// Throughput
//   Results are registered. One beat per cycle is sustained while out_tready
//   is high: the phase counter and shift register update in the same cycle,
//   and the single output register refills while being drained.
// Reset and stalls
//   Synchronous active-low reset returns to idle with no result valid and
//   the registers at their defaults. While out_tready is low with a result
//   held, in_tready drops and the held beat stays unchanged.
`timescale 1ns / 1ps

module ir_pulse_width_frame_transmitter #(
  parameter int unsigned WORD_BITS       = 32,
  parameter int unsigned TICK_COUNT_BITS = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  // input stream
  input  logic                in_tvalid,
  output logic                in_tready,
  input  irpw_pkg::cmd_t      in_tdata,   // [31:0] command_word
  input  logic                in_tuser,   // [0] opcode
  // result stream
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata,  // [0] carrier_on, [1] busy_res, [7:2] zero
  output logic                out_tlast,  // frame_done
  // configuration writes
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  irpw_pkg::cfg_addr_t cfg_index,
  input  irpw_pkg::len_t      cfg_data
);
  import irpw_pkg::*;

  // Compare width covers both the tick counter and the 10-bit lengths, plus carry
  localparam int unsigned CMP_W =
    ((TICK_COUNT_BITS > LEN_W) ? TICK_COUNT_BITS : LEN_W) + 1;

  // Configuration registers
  len_t     header_ticks_r, gap_ticks_r, zero_ticks_r, one_ticks_r;
  bit_idx_t last_bit_index_r;

  // Frame state
  phase_t                     phase_r, phase_nxt;
  logic [TICK_COUNT_BITS-1:0] elapsed_r, elapsed_nxt;
  bitpos_t                    bitpos_r, bitpos_nxt;
  logic [WORD_BITS-1:0]       shift_r, shift_nxt;

  // Result register
  logic out_valid_r;
  logic carrier_r, carrier_nxt;
  logic busy_r, busy_nxt;
  logic done_r, done_nxt;

  logic                 in_fire;
  logic                 cur_bit;
  logic [WORD_BITS-1:0] load_word;
  len_t                 ivl_len;
  logic [CMP_W-1:0]     cnt_inc;
  logic                 ivl_end;

  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  // Config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_ticks_r   <= RST_HEADER_TICKS;
      gap_ticks_r      <= RST_GAP_TICKS;
      zero_ticks_r     <= RST_ZERO_TICKS;
      one_ticks_r      <= RST_ONE_TICKS;
      last_bit_index_r <= RST_LAST_BIT_INDEX;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HEADER_TICKS:   header_ticks_r   <= cfg_data;
        REG_GAP_TICKS:      gap_ticks_r      <= cfg_data;
        REG_ZERO_TICKS:     zero_ticks_r     <= cfg_data;
        REG_ONE_TICKS:      one_ticks_r      <= cfg_data;
        REG_LAST_BIT_INDEX: last_bit_index_r <= cfg_data[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  // Command word fitted to the shift register; bits past 32 are zero
  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      load_word[i] = (i < CMD_W) ? in_tdata[i % CMD_W] : 1'b0;
    end
  end

  // Current bit; positions beyond the word send as zero
  always_comb begin
    cur_bit = 1'b0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (bitpos_r == BITPOS_W'(i)) cur_bit = shift_r[i];
    end
  end

  // Interval length for the running phase
  always_comb begin
    unique case (phase_r)
      PH_HEAD:          ivl_len = header_ticks_r;
      PH_HGAP, PH_BGAP: ivl_len = gap_ticks_r;
      PH_MARK:          ivl_len = cur_bit ? one_ticks_r : zero_ticks_r;
      default:          ivl_len = header_ticks_r;
    endcase
  end

  // Interval ends on reaching its length (zero acts as one) or counter saturation
  assign cnt_inc = CMP_W'(elapsed_r) + CMP_W'(1);
  assign ivl_end = (cnt_inc >= CMP_W'(ivl_len)) || (&elapsed_r);

  // Next frame state and result
  always_comb begin
    phase_nxt   = phase_r;
    elapsed_nxt = elapsed_r;
    bitpos_nxt  = bitpos_r;
    shift_nxt   = shift_r;
    carrier_nxt = 1'b0;
    busy_nxt    = 1'b0;
    done_nxt    = 1'b0;
    if (in_tuser == OP_SEND) begin
      shift_nxt   = load_word;
      bitpos_nxt  = BITPOS_W'(last_bit_index_r);
      elapsed_nxt = '0;
      phase_nxt   = PH_HEAD;
      busy_nxt    = 1'b1;
    end else begin
      elapsed_nxt = ivl_end ? '0 : cnt_inc[TICK_COUNT_BITS-1:0];
      unique case (phase_r)
        PH_HEAD: begin
          busy_nxt    = 1'b1;
          carrier_nxt = 1'b1;
          if (ivl_end) phase_nxt = PH_HGAP;
        end
        PH_HGAP, PH_BGAP: begin
          busy_nxt = 1'b1;
          if (ivl_end) phase_nxt = PH_MARK;
        end
        PH_MARK: begin
          busy_nxt    = 1'b1;
          carrier_nxt = 1'b1;
          if (ivl_end) begin
            if (bitpos_r == '0) begin
              phase_nxt = PH_IDLE;
              shift_nxt = '0;
              done_nxt  = 1'b1;
            end else begin
              bitpos_nxt = bitpos_r - BITPOS_W'(1);
              phase_nxt  = PH_BGAP;
            end
          end
        end
        default: begin
          // idle or unused code: stay idle with the counter cleared
          phase_nxt   = PH_IDLE;
          elapsed_nxt = '0;
        end
      endcase
    end
  end

  // State update on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      elapsed_r <= '0;
      bitpos_r  <= '0;
      shift_r   <= '0;
    end else if (in_fire) begin
      phase_r   <= phase_nxt;
      elapsed_r <= elapsed_nxt;
      bitpos_r  <= bitpos_nxt;
      shift_r   <= shift_nxt;
    end
  end

  // Result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      carrier_r <= carrier_nxt;
      busy_r    <= busy_nxt;
      done_r    <= done_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = done_r;
  always_comb begin
    out_tdata                  = '0;
    out_tdata[OUT_CARRIER_BIT] = carrier_r;
    out_tdata[OUT_BUSY_BIT]    = busy_r;
  end

endmodule

// ----- rtl/irpw_port_checker.sv -----
// irpw_port_checker: port-level assertions for the IR frame transmitter.
// Depends on irpw_pkg; bound to ir_pulse_width_frame_transmitter below.
`timescale 1ns / 1ps

module irpw_port_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_tvalid,
  input logic                in_tready,
  input logic                in_tuser,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [7:0]          out_tdata,
  input logic                out_tlast
);
  import irpw_pkg::*;

  // Nothing comes out in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result beat valid right after reset");

  // A send beat yields busy, carrier off, not done, on the next cycle
  a_send_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == OP_SEND) |=>
      out_tvalid && out_tdata[OUT_BUSY_BIT] && !out_tdata[OUT_CARRIER_BIT] && !out_tlast)
    else $error("send beat did not give a busy, carrier-off result");

  // Frame end is only reported while a frame was in progress with carrier on
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[OUT_BUSY_BIT] && out_tdata[OUT_CARRIER_BIT])
    else $error("frame end outside a carrier mark");

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result beat changed");

endmodule

bind ir_pulse_width_frame_transmitter irpw_port_checker u_irpw_port_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// ----- verif/ir_pulse_width_frame_transmitter_tb.sv -----
// ir_pulse_width_frame_transmitter_tb: self-checking bench for the IR frame sender.
// Predicts every result beat from its own frame sequencer and checks it in order.
// Depends on irpw_pkg and the ir_pulse_width_frame_transmitter top level only.
`timescale 1ns / 1ps

module ir_pulse_width_frame_transmitter_tb;
  import irpw_pkg::*;

  localparam int STALL_LIMIT = 2000;
  // indexes past the register list, expected to be ignored
  localparam cfg_addr_t REG_SPARE_LO = 3'd5;
  localparam cfg_addr_t REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic carrier;
    logic busy;
    logic done;
  } tx_res_t;

  logic      clk;
  logic      rst_n      = 1'b0;
  logic      in_tvalid  = 1'b0;
  logic      in_tready;
  cmd_t      in_tdata   = '0;
  logic      in_tuser   = OP_TICK;
  logic      out_tvalid;
  logic      out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic      out_tlast;
  logic      cfg_valid  = 1'b0;
  logic      cfg_ready;
  cfg_addr_t cfg_index  = REG_HEADER_TICKS;
  len_t      cfg_data   = '0;

  ir_pulse_width_frame_transmitter u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Predicted frame sequencer state and registers
  phase_t   tx_phase   = PH_IDLE;
  len_t     tx_elapsed = '0;
  bitpos_t  tx_bitpos  = '0;
  cmd_t     tx_word    = '0;
  len_t     hdr_len    = RST_HEADER_TICKS;
  len_t     gap_len    = RST_GAP_TICKS;
  len_t     zero_len   = RST_ZERO_TICKS;
  len_t     one_len    = RST_ONE_TICKS;
  bit_idx_t last_idx   = RST_LAST_BIT_INDEX;

  tx_res_t tx_expq[$];
  int      err_count      = 0;
  int      send_idle_pct  = 0;
  int      recv_stall_pct = 0;
  int      quiet_cycles   = 0;
  tx_res_t got_exp;
  logic [7:0] exp_byte;

  // One tick of an interval of len ticks; a zero length behaves as one,
  // and a saturated counter ends the interval
  function automatic logic interval_end(input len_t len);
    logic [LEN_W:0] nxt;
    nxt = tx_elapsed + 1'b1;
    if (nxt >= len || tx_elapsed == '1) begin
      tx_elapsed = '0;
      return 1'b1;
    end
    tx_elapsed = nxt[LEN_W-1:0];
    return 1'b0;
  endfunction

  // Advance the predicted sequencer by one beat and return its result
  function automatic tx_res_t frame_step(input logic op, input cmd_t word);
    tx_res_t r;
    logic    bit_val;
    r = '0;
    if (op == OP_SEND) begin
      tx_word    = word;
      tx_bitpos  = bitpos_t'(last_idx);
      tx_elapsed = '0;
      tx_phase   = PH_HEAD;
      r.busy     = 1'b1;
    end else begin
      case (tx_phase)
        PH_HEAD: begin
          r.busy    = 1'b1;
          r.carrier = 1'b1;
          if (interval_end(hdr_len)) tx_phase = PH_HGAP;
        end
        PH_HGAP, PH_BGAP: begin
          r.busy = 1'b1;
          if (interval_end(gap_len)) tx_phase = PH_MARK;
        end
        PH_MARK: begin
          r.busy    = 1'b1;
          r.carrier = 1'b1;
          bit_val   = (tx_bitpos < CMD_W) ? tx_word[tx_bitpos[4:0]] : 1'b0;
          if (interval_end(bit_val ? one_len : zero_len)) begin
            if (tx_bitpos == '0) begin
              tx_phase = PH_IDLE;
              tx_word  = '0;
              r.done   = 1'b1;
            end else begin
              tx_bitpos = tx_bitpos - 1'b1;
              tx_phase  = PH_BGAP;
            end
          end
        end
        default: begin
          tx_phase   = PH_IDLE;
          tx_elapsed = '0;
        end
      endcase
    end
    return r;
  endfunction

  // Mirror of a register write
  function automatic void reg_update(input cfg_addr_t idx, input len_t val);
    case (idx)
      REG_HEADER_TICKS:   hdr_len  = val;
      REG_GAP_TICKS:      gap_len  = val;
      REG_ZERO_TICKS:     zero_len = val;
      REG_ONE_TICKS:      one_len  = val;
      REG_LAST_BIT_INDEX: last_idx = val[IDX_W-1:0];
      default: ;
    endcase
  endfunction

  // Receiver back-pressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (tx_expq.size() == 0) begin
        $display("%0t: result beat with nothing expected, tdata %h tlast %b",
                 $time, out_tdata, out_tlast);
        err_count++;
      end else begin
        got_exp  = tx_expq.pop_front();
        exp_byte = '0;
        exp_byte[OUT_CARRIER_BIT] = got_exp.carrier;
        exp_byte[OUT_BUSY_BIT]    = got_exp.busy;
        if (out_tdata !== exp_byte) begin
          $display("%0t: carrier/busy mismatch, expected tdata %h, actual %h",
                   $time, exp_byte, out_tdata);
          err_count++;
        end
        if (out_tlast !== got_exp.done) begin
          $display("%0t: frame_done mismatch, expected %b, actual %b",
                   $time, got_exp.done, out_tlast);
          err_count++;
        end
      end
    end
  end

  // Watchdog: too long without any beat on any channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("ir_pulse_width_frame_transmitter verification failed");
      $finish;
    end
  end

  // Send one input beat; valid is left high for the caller to reuse or drop
  task automatic send_beat(input logic op, input cmd_t word);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    tx_expq.push_back(frame_step(op, word));
  endtask

  // Tick until the predicted frame has ended
  task automatic finish_frame();
    while (tx_phase != PH_IDLE) send_beat(OP_TICK, $urandom);
  endtask

  // Stop sending and wait for every outstanding result
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (tx_expq.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_addr_t idx, input len_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    reg_update(idx, val);
  endtask

  // Rewrite every register with the block idle
  task automatic apply_cfg(input len_t h, input len_t g, input len_t z, input len_t o,
                           input len_t lb);
    finish_frame();
    settle();
    write_reg(REG_HEADER_TICKS, h);
    write_reg(REG_GAP_TICKS, g);
    write_reg(REG_ZERO_TICKS, z);
    write_reg(REG_ONE_TICKS, o);
    write_reg(REG_LAST_BIT_INDEX, lb);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Idle ticks straight after reset report carrier off and not busy
  task automatic test_idle_after_reset();
    repeat (3) send_beat(OP_TICK, $urandom);
  endtask

  // Header, gap and first bits with the reset register values, then the
  // rest of the 24-bit frame with short lengths written part way through a mark
  task automatic test_default_frame();
    send_beat(OP_SEND, 32'hA5C3_0F96);
    repeat (70) send_beat(OP_TICK, $urandom);
    settle();
    write_reg(REG_HEADER_TICKS, 10'd1);
    write_reg(REG_GAP_TICKS, 10'd1);
    write_reg(REG_ZERO_TICKS, 10'd1);
    write_reg(REG_ONE_TICKS, 10'd1);
    cfg_valid <= 1'b0;
    @(posedge clk);
    finish_frame();
  endtask

  // Shortest lengths, widest and narrowest frames, zero lengths acting as one
  task automatic test_min_lengths();
    apply_cfg(10'd1, 10'd1, 10'd1, 10'd1, 10'd31);
    send_beat(OP_SEND, 32'hA5C3_0F96);
    finish_frame();
    apply_cfg(10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
    send_beat(OP_SEND, 32'h0000_0001);
    finish_frame();
    send_beat(OP_SEND, 32'hFFFF_FFFE);
    finish_frame();
  endtask

  // A send mid-frame restarts with the new word
  task automatic test_abort_restart();
    apply_cfg(10'd3, 10'd2, 10'd2, 10'd4, 10'd3);
    send_beat(OP_SEND, 32'h0000_000A);
    repeat (2) send_beat(OP_TICK, $urandom);
    send_beat(OP_SEND, 32'h0000_0005);
    repeat (6) send_beat(OP_TICK, $urandom);
    send_beat(OP_SEND, 32'h0000_000F);
    send_beat(OP_SEND, 32'h0000_0003);
    repeat (4) send_beat(OP_TICK, $urandom);
    send_beat(OP_SEND, 32'h0000_0009);
    finish_frame();
  endtask

  // Longer lengths; upper bits of the bit index data are dropped
  task automatic test_max_lengths();
    apply_cfg(10'd30, 10'd1, 10'd20, 10'd1, 10'h3E1);
    send_beat(OP_SEND, 32'h0000_0002);
    finish_frame();
  endtask

  // Writes to indexes past the register list change nothing
  task automatic test_spare_index();
    apply_cfg(10'd2, 10'd1, 10'd1, 10'd3, 10'd2);
    write_reg(REG_SPARE_LO, 10'h3FF);
    write_reg(REG_SPARE_HI, 10'h3FF);
    write_reg(REG_SPARE_HI, 10'h000);
    cfg_valid <= 1'b0;
    send_beat(OP_SEND, 32'h0000_0005);
    finish_frame();
  endtask

  // Random traffic: mostly complete frames, some restarts mid-frame
  task automatic test_random_traffic(input int n_items, input int idle_pct,
                                     input int stall_pct);
    logic op;
    for (int k = 0; k < n_items; k++) begin
      if (k % 56 == 0) begin
        apply_cfg(len_t'($urandom_range(0, 8)), len_t'($urandom_range(0, 5)),
                  len_t'($urandom_range(0, 6)), len_t'($urandom_range(0, 8)),
                  {5'($urandom_range(0, 31)), 5'($urandom_range(0, 12))});
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
      end
      if (tx_phase == PH_IDLE) op = 1'($urandom_range(1));
      else op = ($urandom_range(99) < 4) ? OP_SEND : OP_TICK;
      send_beat(op, $urandom);
    end
    finish_frame();
    settle();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  // Test sequence
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_after_reset();
    test_default_frame();
    test_min_lengths();
    test_abort_restart();
    test_max_lengths();
    test_spare_index();
    test_random_traffic(30, 0, 0);
    test_random_traffic(30, 46, 0);
    test_random_traffic(30, 0, 46);
    test_random_traffic(30, 30, 30);
    settle();
    repeat (4) @(posedge clk);
    if (err_count == 0 && tx_expq.size() == 0) begin
      $display("ir_pulse_width_frame_transmitter verification clean");
    end else begin
      $display("ir_pulse_width_frame_transmitter verification failed");
    end
    $finish;
  end

endmodule
